@@ design/stb_pkg.sv @@
// Shared types, constants and helpers for the software timer bank.
`timescale 1ns / 1ps
`default_nettype none
package stb_pkg;
    localparam int NUM_TIMERS  = 32;
    localparam int COUNT_WIDTH = 32;
    localparam int MAX_RESULTS = 32;
    localparam int HEAD_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int WALK_W      = $clog2(NUM_TIMERS + 1);
    localparam int SCALE_W     = 16;
    localparam int PROD_W      = 32;
    localparam int WIDE_W      = (COUNT_WIDTH > PROD_W) ? COUNT_WIDTH : PROD_W;

    localparam int PER_MINUTE = 60;
    localparam int PER_SECOND = 10;
    localparam int PER_TENTH  = 100;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_GET     = 3'd2;
    localparam logic [2:0] OP_STANDBY = 3'd3;
    localparam logic [2:0] OP_STOP    = 3'd4;
    localparam logic [2:0] OP_CLOSE   = 3'd5;
    localparam logic [2:0] OP_TICK    = 3'd6;
    localparam logic [2:0] OP_POLL    = 3'd7;

    localparam logic [1:0] BASE_MS     = 2'd0;
    localparam logic [1:0] BASE_TENTHS = 2'd1;
    localparam logic [1:0] BASE_SEC    = 2'd2;
    localparam logic [1:0] BASE_MIN    = 2'd3;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        logic                   expired;
        logic                   paused;
        logic [1:0]             base;
    } t_timer;

    function automatic logic [SCALE_W-1:0] scale_of(input logic [1:0] code);
        logic [SCALE_W-1:0] s;
        unique case (code)
            BASE_TENTHS: s = SCALE_W'(PER_TENTH);
            BASE_SEC:    s = SCALE_W'(PER_SECOND * PER_TENTH);
            BASE_MIN:    s = SCALE_W'(PER_MINUTE * PER_SECOND * PER_TENTH);
            default:     s = SCALE_W'(1);
        endcase
        return s;
    endfunction
endpackage
`default_nettype wire

@@ design/stb_cell.sv @@
// One timer cell of the rotating ring.
`timescale 1ns / 1ps
`default_nettype none
module stb_cell
    import stb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_clr,
    input  wire         i_en,
    input  wire t_timer i_d,
    output t_timer      o_q
);
    t_timer r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_q <= '0;
        end else if (i_en) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

@@ design/stb_div.sv @@
// Count-to-base-units divider by reciprocal multiplication; operands and product are registered.
`timescale 1ns / 1ps
`default_nettype none
module stb_div
    import stb_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  wire [COUNT_WIDTH-1:0]  i_dividend,
    input  wire [1:0]              i_base,
    output logic                   o_done,
    output logic [COUNT_WIDTH-1:0] o_quot
);
    // q = (x * M) >> s, exact for any 32-bit count
    localparam logic [31:0] MAGIC_TENTHS = 32'd2748779070; // 2^38 / 100, rounded up
    localparam logic [31:0] MAGIC_SEC    = 32'd2199023256; // 2^41 / 1000, rounded up
    localparam logic [31:0] MAGIC_MIN    = 32'd2345624806; // 2^47 / 60000, rounded up
    localparam int          PW           = COUNT_WIDTH + 32;

    logic                   r_busy, r_done;
    logic [1:0]             r_base;
    logic [COUNT_WIDTH-1:0] r_x;
    logic [31:0]            r_m;
    logic [PW-1:0]          r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= i_start;
            r_done <= r_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= i_dividend;
            r_base <= i_base;
            unique case (i_base)
                BASE_TENTHS: r_m <= MAGIC_TENTHS;
                BASE_SEC:    r_m <= MAGIC_SEC;
                BASE_MIN:    r_m <= MAGIC_MIN;
                default:     r_m <= 32'd1;
            endcase
        end
        if (r_busy) begin
            r_prod <= PW'(r_x) * PW'(r_m);
        end
    end

    always_comb begin
        unique case (r_base)
            BASE_TENTHS: o_quot = COUNT_WIDTH'(r_prod >> 38);
            BASE_SEC:    o_quot = COUNT_WIDTH'(r_prod >> 41);
            BASE_MIN:    o_quot = COUNT_WIDTH'(r_prod >> 47);
            default:     o_quot = r_x;
        endcase
    end

    assign o_done = r_done;
endmodule
`default_nettype wire

@@ design/software_timer_bank_core.sv @@
// Top level: timer bank built as a rotating ring of timer cells.
// A single-timer op rotates its cell to the head, applies the op there and then registers
//   its beat; get also waits for the registered multiply of the divider.
// Tick walks the ring once; poll seeks timer 0 and then walks the ring once, and
//   output stalls can hold a poll walk and the final beat.
// One item at a time; the next one is taken once its last beat is registered.
// Synchronous active-low reset clears all timers, the sequencer and the output.
`timescale 1ns / 1ps
`default_nettype none
module software_timer_bank_core
    import stb_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_operation,
    input  wire  [4:0]  i_timer_index,
    input  wire  [15:0] i_time_value,
    input  wire  [1:0]  i_time_base,
    input  wire         i_pause,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [4:0]  o_result_index,
    output logic [31:0] o_read_value,
    output logic        o_expired_valid,
    output logic        o_last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEEK  = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_op;
    logic [4:0]        r_idx;
    logic [15:0]       r_tv;
    logic [1:0]        r_tb;
    logic              r_ps;
    logic [HEAD_W-1:0] r_head, r_target;
    logic [WALK_W-1:0] r_cnt;
    logic              r_pend_v;
    logic [4:0]        r_pend_idx;
    logic [4:0]        r_res_idx;
    logic [31:0]       r_res_val;
    logic              r_res_exp;
    logic              r_ov, r_o_exp, r_o_last;
    logic [4:0]        r_o_idx;
    logic [31:0]       r_o_val;

    t_timer cells [NUM_TIMERS];
    t_timer head, head_new;

    // ring control
    logic shift, hload, clr_all, accept, out_free, ok, stall, walk_push, walk_end;
    logic div_start, div_done;
    logic [COUNT_WIDTH-1:0] quot;

    // scaling multiplier with saturation
    logic [SCALE_W-1:0]     scale;
    logic [PROD_W-1:0]      prod;
    logic [WIDE_W-1:0]      wide;
    logic [COUNT_WIDTH-1:0] scaled;

    assign accept   = i_valid && o_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign out_free = !r_ov || i_ready;
    assign ok       = int'(r_idx) < NUM_TIMERS;
    assign head     = cells[0];

    always_comb begin
        scale  = scale_of((r_op == OP_START) ? r_tb : head.base);
        prod   = PROD_W'(r_tv) * PROD_W'(scale);
        wide   = WIDE_W'(prod);
        scaled = (wide > WIDE_W'({COUNT_WIDTH{1'b1}})) ? {COUNT_WIDTH{1'b1}}
                                                       : COUNT_WIDTH'(wide);
    end

    // head processing: the cell at the head is rewritten as it passes;
    // cells rotated past during a seek go round unchanged
    always_comb begin
        head_new = head;
        if (r_state == S_WALK) begin
            if (r_op == OP_TICK) begin
                if (head.count != '0 && !head.paused) begin
                    head_new.count = head.count - 1'b1;
                    if (head.count == COUNT_WIDTH'(1)) head_new.expired = 1'b1;
                end
            end else begin
                head_new.expired = 1'b0;
            end
        end else if (r_state == S_APPLY) begin
            unique case (r_op)
                OP_START: begin
                    head_new.count   = scaled;
                    head_new.base    = r_tb;
                    head_new.expired = (scaled == '0);
                end
                OP_SET:     head_new.count  = scaled;
                OP_STANDBY: head_new.paused = r_ps;
                OP_STOP:    head_new        = '0;
                default:    head_new        = head;
            endcase
        end
    end

    // poll: an expired timer is held as pending so the final one can carry last
    assign stall     = (r_state == S_WALK) && (r_op == OP_POLL) && head.expired
                       && r_pend_v && !out_free;
    assign walk_push = (r_state == S_WALK) && (r_op == OP_POLL) && head.expired
                       && r_pend_v && out_free;
    assign shift     = ((r_state == S_WALK) && !stall)
                       || ((r_state == S_SEEK) && (r_head != r_target));
    assign walk_end  = (r_state == S_WALK) && !stall
                       && (r_cnt == WALK_W'(NUM_TIMERS - 1));
    assign hload     = (r_state == S_APPLY) && (r_op != OP_CLOSE);
    assign clr_all   = (r_state == S_APPLY) && (r_op == OP_CLOSE);
    assign div_start = (r_state == S_APPLY) && (r_op == OP_GET);

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_ring
        t_timer d;
        logic   en;
        if (k == NUM_TIMERS - 1) begin : g_tail
            assign d = head_new;
        end else if (k == 0) begin : g_head
            assign d = shift ? cells[k+1] : head_new;
        end else begin : g_mid
            assign d = cells[k+1];
        end
        assign en = shift || ((k == 0) && hload);
        stb_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_clr   (clr_all),
            .i_en    (en),
            .i_d     (d),
            .o_q     (cells[k])
        );
    end

    stb_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (head.count),
        .i_base     (head.base),
        .o_done     (div_done),
        .o_quot     (quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == OP_TICK) begin
                        n_state = S_WALK;
                    end else if (i_operation == OP_POLL
                                 || i_operation == OP_CLOSE) begin
                        n_state = (i_operation == OP_POLL) ? S_SEEK : S_APPLY;
                    end else if (int'(i_timer_index) < NUM_TIMERS) begin
                        n_state = S_SEEK;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SEEK: begin
                if (r_head == r_target) n_state = (r_op == OP_POLL) ? S_WALK : S_APPLY;
            end
            S_APPLY: n_state = (r_op == OP_GET) ? S_DIV : S_EMIT;
            S_WALK:  if (walk_end) n_state = S_EMIT;
            S_DIV:   if (div_done) n_state = S_EMIT;
            S_EMIT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (shift) begin
                r_head <= (r_head == HEAD_W'(NUM_TIMERS - 1)) ? '0 : r_head + 1'b1;
            end
            if (accept) begin
                r_cnt    <= '0;
                r_pend_v <= 1'b0;
            end else if ((r_state == S_WALK) && !stall) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_op == OP_POLL && head.expired) r_pend_v <= 1'b1;
            end
            if ((r_state == S_EMIT && out_free) || walk_push) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_operation;
            r_idx     <= i_timer_index;
            r_tv      <= i_time_value;
            r_tb      <= i_time_base;
            r_ps      <= i_pause;
            r_target  <= (i_operation == OP_POLL) ? '0 : HEAD_W'(i_timer_index);
            r_res_idx <= i_timer_index;
            r_res_val <= '0;
            r_res_exp <= 1'b0;
        end
        if ((r_state == S_WALK) && !stall && (r_op == OP_POLL)) begin
            if (head.expired) begin
                r_pend_idx <= 5'(r_head);
                if (walk_end) begin
                    r_res_idx <= 5'(r_head);
                    r_res_exp <= 1'b1;
                end
            end else if (walk_end && r_pend_v) begin
                r_res_idx <= r_pend_idx;
                r_res_exp <= 1'b1;
            end
        end
        if ((r_state == S_DIV) && div_done && ok) r_res_val <= 32'(quot);
        if (walk_push) begin
            r_o_idx  <= r_pend_idx;
            r_o_val  <= '0;
            r_o_exp  <= 1'b1;
            r_o_last <= 1'b0;
        end else if (r_state == S_EMIT && out_free) begin
            r_o_idx  <= r_res_idx;
            r_o_val  <= r_res_val;
            r_o_exp  <= r_res_exp;
            r_o_last <= 1'b1;
        end
    end

    assign o_valid         = r_ov;
    assign o_result_index  = r_o_idx;
    assign o_read_value    = r_o_val;
    assign o_expired_valid = r_o_exp;
    assign o_last          = r_o_last;
endmodule
`default_nettype wire

@@ design/stb_checker.sv @@
// Port-level assertions for the timer bank, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module stb_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_ready,
    input wire        o_valid,
    input wire        i_ready,
    input wire [4:0]  o_result_index,
    input wire [31:0] o_read_value,
    input wire        o_expired_valid,
    input wire        o_last
);
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is in progress");

    a_mid_expired: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> o_expired_valid)
        else $error("non-final beat that is not an expired report");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_expired_valid) |-> (o_read_value == 32'd0))
        else $error("expired report carries a value");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_index)
            && $stable(o_read_value) && $stable(o_last)))
        else $error("result beat changed while stalled");
endmodule

bind software_timer_bank_core stb_checker u_stb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_ready         (o_ready),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_result_index  (o_result_index),
    .o_read_value    (o_read_value),
    .o_expired_valid (o_expired_valid),
    .o_last          (o_last)
);
`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for the software timer bank core.
`timescale 1ns / 1ps
module testbench
    import stb_pkg::*;
();

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_operation;
    logic [4:0]  i_timer_index;
    logic [15:0] i_time_value;
    logic [1:0]  i_time_base;
    logic        i_pause;
    logic        o_valid;
    logic        i_ready;
    logic [4:0]  o_result_index;
    logic [31:0] o_read_value;
    logic        o_expired_valid;
    logic        o_last;

    software_timer_bank_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_operation(i_operation), .i_timer_index(i_timer_index),
        .i_time_value(i_time_value), .i_time_base(i_time_base), .i_pause(i_pause),
        .o_valid(o_valid), .i_ready(i_ready), .o_result_index(o_result_index),
        .o_read_value(o_read_value), .o_expired_valid(o_expired_valid),
        .o_last(o_last)
    );

    typedef struct packed {
        logic [4:0]  idx;
        logic [31:0] value;
        logic        expired;
        logic        last;
    } t_timer_report;

    typedef struct {
        logic [2:0]  op;
        logic [4:0]  idx;
        logic [15:0] tv;
        logic [1:0]  tb;
        logic        ps;
        bit          fixed;
        logic [31:0] value;
    } t_cmd_row;

    // shadow of the timer bank
    logic [COUNT_WIDTH-1:0] shadow_count [NUM_TIMERS];
    logic                   shadow_expired [NUM_TIMERS];
    logic                   shadow_paused [NUM_TIMERS];
    logic [1:0]             shadow_base [NUM_TIMERS];

    t_timer_report pending_reports[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  stim_done = 0;
    bit  hold_off = 0;
    bit  calm = 0;

    always begin
        i_clk = 1'b0; #10;
        i_clk = 1'b1; #10;
    end

    function automatic logic [63:0] base_scale(input logic [1:0] code);
        case (code)
            BASE_TENTHS: return 64'd100;
            BASE_SEC:    return 64'd1000;
            BASE_MIN:    return 64'd60000;
            default:     return 64'd1;
        endcase
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] ticks_for(input logic [15:0] t,
                                                         input logic [1:0] code);
        logic [63:0] v;
        v = 64'(t) * base_scale(code);
        if (v > 64'({COUNT_WIDTH{1'b1}})) v = 64'({COUNT_WIDTH{1'b1}});
        return v[COUNT_WIDTH-1:0];
    endfunction

    task automatic clear_shadow(input int k);
        shadow_count[k] = '0;
        shadow_expired[k] = 1'b0;
        shadow_paused[k] = 1'b0;
        shadow_base[k] = BASE_MS;
    endtask

    // Apply one command to the shadow bank and queue the reports it causes.
    task automatic predict_timer_op(input logic [2:0] op, input logic [4:0] idx,
                                    input logic [15:0] tv, input logic [1:0] tb,
                                    input logic ps);
        logic [31:0] value;
        int n;
        t_timer_report r;
        value = '0;
        n = 0;
        case (op)
            OP_START: begin
                shadow_base[idx] = tb;
                shadow_count[idx] = ticks_for(tv, tb);
                shadow_expired[idx] = (shadow_count[idx] == 0);
            end
            OP_SET: shadow_count[idx] = ticks_for(tv, shadow_base[idx]);
            OP_GET: value = 32'(64'(shadow_count[idx]) / base_scale(shadow_base[idx]));
            OP_STANDBY: shadow_paused[idx] = ps;
            OP_STOP: clear_shadow(idx);
            OP_CLOSE: for (int j = 0; j < NUM_TIMERS; j++) clear_shadow(j);
            OP_TICK: begin
                for (int j = 0; j < NUM_TIMERS; j++) begin
                    if (shadow_count[j] != 0 && !shadow_paused[j]) begin
                        shadow_count[j] = shadow_count[j] - 1;
                        if (shadow_count[j] == 0) shadow_expired[j] = 1'b1;
                    end
                end
            end
            default: begin
                for (int j = 0; j < NUM_TIMERS && n < MAX_RESULTS; j++) begin
                    if (shadow_expired[j]) begin
                        shadow_expired[j] = 1'b0;
                        r = '{idx: 5'(j), value: '0, expired: 1'b1, last: 1'b0};
                        pending_reports.push_back(r);
                        n++;
                    end
                end
                if (n > 0) begin
                    r = pending_reports.pop_back();
                    r.last = 1'b1;
                    pending_reports.push_back(r);
                    return;
                end
            end
        endcase
        r = '{idx: idx, value: value, expired: 1'b0, last: 1'b1};
        pending_reports.push_back(r);
    endtask

    // valid stays high after a handshake only when the next beat follows at once
    task automatic send_beat(input logic [2:0] op, input logic [4:0] idx,
                             input logic [15:0] tv, input logic [1:0] tb,
                             input logic ps);
        while (!calm && $urandom_range(99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_timer_index <= idx;
        i_time_value <= tv;
        i_time_base <= tb;
        i_pause <= ps;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_timer_op(op, idx, tv, tb, ps);
    endtask

    // Random command, mostly starts/ticks/polls with mostly small times so that expiries happen.
    task automatic send_random_beat();
        logic [2:0]  op;
        logic [15:0] tv;
        int pick;
        pick = $urandom_range(99);
        if (pick < 25) op = OP_TICK;
        else if (pick < 40) op = OP_POLL;
        else if (pick < 60) op = OP_START;
        else op = 3'($urandom_range(7));
        pick = $urandom_range(9);
        if (pick < 6) tv = 16'($urandom_range(4));
        else if (pick < 8) tv = 16'($urandom);
        else tv = 16'hFFFF;
        send_beat(op, 5'($urandom), tv, 2'($urandom),
                  1'($urandom_range(99) < 20));
    endtask

    // Output side: random ready, compare against the oldest expected report.
    always @(posedge i_clk) begin
        t_timer_report e;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("unexpected beat idx=%0d", o_result_index);
                    error_count++;
                end else begin
                    e = pending_reports.pop_front();
                    if (o_result_index !== e.idx) begin
                        $error("result_index exp %0d got %0d", e.idx, o_result_index);
                        error_count++;
                    end
                    if (o_read_value !== e.value) begin
                        $error("read_value exp %0d got %0d", e.value, o_read_value);
                        error_count++;
                    end
                    if (o_expired_valid !== e.expired) begin
                        $error("expired_valid exp %0b got %0b", e.expired, o_expired_valid);
                        error_count++;
                    end
                    if (o_last !== e.last) begin
                        $error("last exp %0b got %0b", e.last, o_last);
                        error_count++;
                    end
                end
            end
        end
        i_ready <= !hold_off && (calm || $urandom_range(99) >= 31);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    t_cmd_row script[$];

    task automatic add_row(input logic [2:0] op, input logic [4:0] idx,
                           input logic [15:0] tv, input logic [1:0] tb, input logic ps);
        script.push_back('{op, idx, tv, tb, ps, 1'b0, 32'd0});
    endtask

    task automatic add_fixed(input logic [2:0] op, input logic [4:0] idx,
                             input logic [15:0] tv, input logic [1:0] tb,
                             input logic [31:0] value);
        script.push_back('{op, idx, tv, tb, 1'b0, 1'b1, value});
    endtask

    initial begin
        t_cmd_row row;
        t_timer_report e;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_operation = OP_TICK;
        i_timer_index = '0;
        i_time_value = '0;
        i_time_base = BASE_MS;
        i_pause = 1'b0;
        for (int k = 0; k < NUM_TIMERS; k++) clear_shadow(k);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes of every field, full-scale start, zero-time start, pause
        add_fixed(OP_GET, 5'd31, 16'd0, BASE_MS, 32'd0);
        add_fixed(OP_POLL, 5'd7, 16'd0, BASE_MS, 32'd0);
        add_fixed(OP_START, 5'd0, 16'hFFFF, BASE_MIN, 32'd0);
        add_row(OP_GET, 5'd0, 16'd0, BASE_MS, 1'b0);          // full-scale count
        add_row(OP_START, 5'd31, 16'd0, BASE_SEC, 1'b0);      // expires at once
        add_row(OP_START, 5'd1, 16'd2, BASE_MS, 1'b0);
        add_row(OP_START, 5'd2, 16'd1, BASE_TENTHS, 1'b0);
        add_row(OP_STANDBY, 5'd1, 16'd0, BASE_MS, 1'b1);
        add_row(OP_TICK, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_TICK, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_GET, 5'd1, 16'd0, BASE_MS, 1'b0);
        add_row(OP_STANDBY, 5'd1, 16'd0, BASE_MS, 1'b0);
        add_row(OP_TICK, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_TICK, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_POLL, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_SET, 5'd2, 16'hFFFF, BASE_MS, 1'b0);
        add_row(OP_GET, 5'd2, 16'd0, BASE_MS, 1'b0);
        add_row(OP_SET, 5'd2, 16'd0, BASE_MS, 1'b0);          // zero count, idle
        add_row(OP_TICK, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_STOP, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_GET, 5'd0, 16'd0, BASE_MS, 1'b0);
        add_row(OP_POLL, 5'd31, 16'd0, BASE_MS, 1'b0);
        add_fixed(OP_CLOSE, 5'd21, 16'd0, BASE_MS, 32'd0);
        add_fixed(OP_POLL, 5'd10, 16'h5555, BASE_MS, 32'd0);

        foreach (script[k]) begin
            row = script[k];
            send_beat(row.op, row.idx, row.tv, row.tb, row.ps);
            if (row.fixed) begin
                e = pending_reports[pending_reports.size() - 1];
                if (e.value !== row.value || e.expired !== 1'b0) begin
                    $error("directed row %0d: read_value exp %0d got %0d",
                           k, row.value, e.value);
                    error_count++;
                end
            end
        end

        // Fill every timer with a zero start so one poll yields 32 beats,
        // while the receiver holds off so the block stalls.
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
        join_none
        for (int k = 0; k < NUM_TIMERS; k++)
            send_beat(OP_START, 5'(k), 16'd0, 2'($urandom), 1'b0);
        send_beat(OP_POLL, 5'd3, 16'd0, BASE_MS, 1'b0);
        i_valid <= 1'b0;

        // sender pauses until everything has drained
        while (pending_reports.size() != 0) @(posedge i_clk);

        for (int k = 0; k < 113; k++) begin
            calm = (k >= 60 && k < 90);
            send_random_beat();
        end
        i_valid <= 1'b0;
        calm = 1'b0;
        stim_done = 1'b1;

        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (error_count == 0 && pending_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

@@ sim.f @@
design/stb_pkg.sv
design/stb_cell.sv
design/stb_div.sv
design/software_timer_bank_core.sv
design/stb_checker.sv
sim/testbench.sv
